@@ src/isc_pkg.sv @@
package isc_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int TIME_W      = 32;
	localparam int VALUE_W     = 16;
	localparam int MODE_W      = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int ALPHA_FRACTION_BITS_DEF  = 16;
	localparam int MEMORY_FRACTION_BITS_DEF = 8;

	// shared divider: 32-bit products over 16-bit divisors
	localparam int DIV_DIVIDEND_W     = 32;
	localparam int DIV_DIVISOR_W      = 16;
	localparam int DIV_BITS_PER_CYCLE = 2;

	typedef enum logic [MODE_W-1:0] {
		DIG_PASS    = 2'd0,
		DIG_COMPARE = 2'd1,
		DIG_SCHMITT = 2'd2
	} digital_mode_t;

	typedef enum logic [MODE_W-1:0] {
		SMOOTH_NONE     = 2'd0,
		SMOOTH_LOWPASS  = 2'd1,
		SMOOTH_DEBOUNCE = 2'd2
	} smoothing_mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DIGITAL_MODE      = 3'd0,
		REG_SMOOTHING_MODE    = 3'd1,
		REG_THRESHOLD_HIGH    = 3'd2,
		REG_THRESHOLD_LOW     = 3'd3,
		REG_SMOOTHING_ALPHA   = 3'd4,
		REG_DEBOUNCE_DELAY_MS = 3'd5,
		REG_DEBOUNCE_LEVELS   = 3'd6,
		REG_FULL_SCALE        = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MUL_ALPHA_MEM  = 2'd0,
		MUL_BETA_VALUE = 2'd1,
		MUL_VALUE_TOP  = 2'd2,
		MUL_CUR_FS     = 2'd3
	} mul_sel_t;

	typedef enum logic {
		DIV_BY_FULL_SCALE = 1'b0,
		DIV_BY_TOP        = 1'b1
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIGITAL,
		ST_PASS,
		ST_LP_MUL_A,
		ST_LP_MUL_B,
		ST_LP_SUM,
		ST_DB_MUL_LV,
		ST_DB_DIV_LV,
		ST_DB_WAIT_LV,
		ST_DB_UPDATE,
		ST_DB_MUL_OUT,
		ST_DB_DIV_OUT,
		ST_DB_WAIT_OUT,
		ST_DB_RESULT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     digital;
		logic     pass_write;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     lp_write;
		logic     div_start;
		div_sel_t div_sel;
		logic     db_update;
		logic     db_result;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] smoothing_mode;
		logic              div_busy;
	} status_t;

endpackage

@@ src/isc_sample_if.sv @@
interface isc_sample_if;
	logic                             valid;
	logic                             ready;
	logic [isc_pkg::SAMPLE_W-1:0]     sample;
	logic [isc_pkg::TIME_W-1:0]       now_ms;

	modport source (output valid, output sample, output now_ms, input ready);
	modport sink (input valid, input sample, input now_ms, output ready);
endinterface

@@ src/isc_result_if.sv @@
interface isc_result_if;
	logic                          valid;
	logic                          ready;
	logic [isc_pkg::VALUE_W-1:0]   conditioned_value;
	logic [isc_pkg::VALUE_W-1:0]   accepted_level;
	logic                          changed;
	logic                          rose;
	logic                          fell;

	modport source (output valid, output conditioned_value, output accepted_level,
		output changed, output rose, output fell, input ready);
	modport sink (input valid, input conditioned_value, input accepted_level,
		input changed, input rose, input fell, output ready);
endinterface

@@ src/isc_cfg_if.sv @@
interface isc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [isc_pkg::CFG_INDEX_W-1:0]   index;
	logic [isc_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/isc_divider.sv @@
module isc_divider (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [isc_pkg::DIV_DIVIDEND_W-1:0]    dividend,
	input  logic [isc_pkg::DIV_DIVISOR_W-1:0]     divisor,
	output logic [isc_pkg::DIV_DIVIDEND_W-1:0]    quotient,
	output logic                                  busy
);

	localparam int DW     = isc_pkg::DIV_DIVIDEND_W;
	localparam int VW     = isc_pkg::DIV_DIVISOR_W;
	localparam int STEPS  = isc_pkg::DIV_BITS_PER_CYCLE;
	localparam int CYCLES = DW / STEPS;
	localparam int CNT_W  = $clog2(CYCLES);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    div_q;

	logic [DW-1:0]    quo_next;
	logic [VW-1:0]    rem_next;
	logic [VW:0]      trial;

	// restoring division, a few quotient bits per cycle; dividend shifts out as quotient shifts in
	always_comb begin
		quo_next = quo_q;
		rem_next = rem_q;
		trial    = '0;
		for (int i = 0; i < STEPS; i++) begin
			trial    = {rem_next, quo_next[DW-1]};
			quo_next = {quo_next[DW-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_next    = VW'(trial - {1'b0, div_q});
				quo_next[0] = 1'b1;
			end else begin
				rem_next = trial[VW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(CYCLES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_next;
			rem_q <= rem_next;
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;

endmodule

@@ src/isc_datapath.sv @@
module isc_datapath #(
	parameter int ALPHA_FRACTION_BITS  = isc_pkg::ALPHA_FRACTION_BITS_DEF,
	parameter int MEMORY_FRACTION_BITS = isc_pkg::MEMORY_FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  isc_pkg::cmd_t                      cmd,
	output isc_pkg::status_t                   status,
	input  logic                               cfg_write,
	input  logic [isc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [isc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [isc_pkg::SAMPLE_W-1:0]       sample,
	input  logic [isc_pkg::TIME_W-1:0]         now_ms,
	output logic [isc_pkg::VALUE_W-1:0]        conditioned_value,
	output logic [isc_pkg::VALUE_W-1:0]        accepted_level,
	output logic                               changed,
	output logic                               rose,
	output logic                               fell
);

	localparam int VW     = isc_pkg::VALUE_W;
	localparam int TW     = isc_pkg::TIME_W;
	localparam int MEM_W  = VW + MEMORY_FRACTION_BITS;
	localparam int AW     = ALPHA_FRACTION_BITS + 1;
	localparam int OPA_W  = (AW > VW) ? AW : VW;
	localparam int OPB_W  = MEM_W;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int DW     = isc_pkg::DIV_DIVIDEND_W;

	// configuration registers
	logic [isc_pkg::MODE_W-1:0] digital_mode_q;
	logic [isc_pkg::MODE_W-1:0] smoothing_mode_q;
	logic [VW-1:0]              threshold_high_q;
	logic [VW-1:0]              threshold_low_q;
	logic [VW-1:0]              alpha_q;
	logic [VW-1:0]              delay_q;
	logic [VW-1:0]              levels_q;
	logic [VW-1:0]              full_scale_q;

	// filter state
	logic [MEM_W-1:0]           mem_q;
	logic [VW-1:0]              prev_level_q;
	logic [TW-1:0]              last_change_q;

	// working registers
	logic [VW-1:0]              sample_q;
	logic [TW-1:0]              now_q;
	logic [VW-1:0]              v_q;
	logic [PROD_W-1:0]          prod_q;
	logic [PROD_W-1:0]          acc_q;
	logic [VW-1:0]              cur_q;
	logic [VW-1:0]              result_q;
	logic [VW-1:0]              accepted_q;
	logic                       chg_q;
	logic                       up_q;
	logic                       down_q;

	logic [VW-1:0]              out_value_q;
	logic [VW-1:0]              out_level_q;
	logic                       out_chg_q;
	logic                       out_up_q;
	logic                       out_down_q;

	logic                       mode_write;
	logic [VW-1:0]              fs;
	logic [VW-1:0]              top;
	logic [VW-1:0]              v_next;
	logic [OPA_W-1:0]           alpha_x;
	logic [OPA_W-1:0]           one_x;
	logic [AW-1:0]              a_eff;
	logic [AW-1:0]              b_eff;
	logic [OPA_W-1:0]           opa;
	logic [OPB_W-1:0]           opb;
	logic [PROD_W-1:0]          prod_c;
	logic [PROD_W-1:0]          lp_sum;
	logic [DW-1:0]              quotient;
	logic [VW-1:0]              divisor;
	logic [VW-1:0]              lv;
	logic [VW-1:0]              cur_mem;
	logic [TW-1:0]              elapsed;
	logic                       db_accept;
	logic                       div_busy;

	assign mode_write = cfg_write &&
		(cfg_index == isc_pkg::REG_DIGITAL_MODE || cfg_index == isc_pkg::REG_SMOOTHING_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digital_mode_q   <= isc_pkg::DIG_PASS;
			smoothing_mode_q <= isc_pkg::SMOOTH_NONE;
			threshold_high_q <= '0;
			threshold_low_q  <= '0;
			alpha_q          <= '0;
			delay_q          <= '0;
			levels_q         <= VW'(2);
			full_scale_q     <= VW'(1);
		end else if (cfg_write) begin
			case (isc_pkg::cfg_reg_t'(cfg_index))
				isc_pkg::REG_DIGITAL_MODE:      digital_mode_q   <= cfg_data[isc_pkg::MODE_W-1:0];
				isc_pkg::REG_SMOOTHING_MODE:    smoothing_mode_q <= cfg_data[isc_pkg::MODE_W-1:0];
				isc_pkg::REG_THRESHOLD_HIGH:    threshold_high_q <= cfg_data;
				isc_pkg::REG_THRESHOLD_LOW:     threshold_low_q  <= cfg_data;
				isc_pkg::REG_SMOOTHING_ALPHA:   alpha_q          <= cfg_data;
				isc_pkg::REG_DEBOUNCE_DELAY_MS: delay_q          <= cfg_data;
				isc_pkg::REG_DEBOUNCE_LEVELS:   levels_q         <= cfg_data;
				isc_pkg::REG_FULL_SCALE:        full_scale_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero full scale acts as one, fewer than two levels act as two
	assign fs  = (full_scale_q == '0) ? VW'(1) : full_scale_q;
	assign top = (levels_q < VW'(2)) ? VW'(1) : levels_q - VW'(1);

	always_comb begin
		case (digital_mode_q)
			isc_pkg::DIG_COMPARE: v_next = (sample_q > threshold_high_q) ? fs : '0;
			isc_pkg::DIG_SCHMITT: begin
				if (|mem_q) begin
					v_next = (sample_q >= threshold_low_q) ? fs : '0;
				end else begin
					v_next = (sample_q > threshold_high_q) ? fs : '0;
				end
			end
			default: v_next = sample_q;
		endcase
	end

	// alpha above one is taken as one
	assign alpha_x = OPA_W'(alpha_q);
	assign one_x   = OPA_W'(1) << ALPHA_FRACTION_BITS;
	assign a_eff   = AW'((alpha_x > one_x) ? one_x : alpha_x);
	assign b_eff   = (AW'(1) << ALPHA_FRACTION_BITS) - a_eff;

	always_comb begin
		case (cmd.mul_sel)
			isc_pkg::MUL_ALPHA_MEM: begin
				opa = OPA_W'(a_eff);
				opb = mem_q;
			end
			isc_pkg::MUL_BETA_VALUE: begin
				opa = OPA_W'(b_eff);
				opb = OPB_W'(v_q) << MEMORY_FRACTION_BITS;
			end
			isc_pkg::MUL_VALUE_TOP: begin
				opa = OPA_W'(v_q);
				opb = OPB_W'(top);
			end
			isc_pkg::MUL_CUR_FS: begin
				opa = OPA_W'(cur_q);
				opb = OPB_W'(fs);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign prod_c = opa * opb;
	assign lp_sum = acc_q + prod_q;

	assign divisor = (cmd.div_sel == isc_pkg::DIV_BY_TOP) ? top : fs;

	isc_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q[DW-1:0]),
		.divisor  (divisor),
		.quotient (quotient),
		.busy     (div_busy)
	);

	// debounce: saturate the level, accept it once stable for longer than the delay
	assign lv        = (quotient > DW'(top)) ? top : quotient[VW-1:0];
	assign cur_mem   = mem_q[MEM_W-1 -: VW];
	assign elapsed   = now_q - last_change_q;
	assign db_accept = (lv == prev_level_q) && (elapsed > TW'(delay_q)) && (lv != cur_mem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_q <= '0;
		end else if (mode_write) begin
			mem_q <= '0;
		end else if (cmd.pass_write) begin
			mem_q <= MEM_W'(v_q) << MEMORY_FRACTION_BITS;
		end else if (cmd.lp_write) begin
			mem_q <= lp_sum[ALPHA_FRACTION_BITS +: MEM_W];
		end else if (cmd.db_update && db_accept) begin
			mem_q <= MEM_W'(lv) << MEMORY_FRACTION_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q  <= '0;
			last_change_q <= '0;
		end else if (cmd.db_update) begin
			prev_level_q <= lv;
			if (lv != prev_level_q) begin
				last_change_q <= now_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q <= sample;
			now_q    <= now_ms;
		end
		if (cmd.digital) begin
			v_q        <= v_next;
			accepted_q <= '0;
			chg_q      <= 1'b0;
			up_q       <= 1'b0;
			down_q     <= 1'b0;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_c;
			acc_q  <= prod_q;
		end
		if (cmd.pass_write) begin
			result_q <= v_q;
		end
		if (cmd.lp_write) begin
			result_q <= lp_sum[ALPHA_FRACTION_BITS + MEMORY_FRACTION_BITS +: VW];
		end
		if (cmd.db_update) begin
			cur_q      <= db_accept ? lv : cur_mem;
			accepted_q <= db_accept ? lv : cur_mem;
			chg_q      <= db_accept;
			up_q       <= db_accept && (lv > cur_mem);
			down_q     <= db_accept && (lv < cur_mem);
		end
		if (cmd.db_result) begin
			result_q <= quotient[VW-1:0];
		end
		if (cmd.load_out) begin
			out_value_q <= result_q;
			out_level_q <= accepted_q;
			out_chg_q   <= chg_q;
			out_up_q    <= up_q;
			out_down_q  <= down_q;
		end
	end

	assign status.smoothing_mode = smoothing_mode_q;
	assign status.div_busy       = div_busy;

	assign conditioned_value = out_value_q;
	assign accepted_level    = out_level_q;
	assign changed           = out_chg_q;
	assign rose              = out_up_q;
	assign fell              = out_down_q;

endmodule

@@ src/isc_ctrl.sv @@
module isc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  isc_pkg::status_t status,
	output isc_pkg::cmd_t    cmd
);

	isc_pkg::state_t state_q;
	isc_pkg::state_t state_next;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isc_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			isc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_next  = isc_pkg::ST_DIGITAL;
				end
			end
			isc_pkg::ST_DIGITAL: begin
				cmd.digital = 1'b1;
				case (status.smoothing_mode)
					isc_pkg::SMOOTH_LOWPASS:  state_next = isc_pkg::ST_LP_MUL_A;
					isc_pkg::SMOOTH_DEBOUNCE: state_next = isc_pkg::ST_DB_MUL_LV;
					default:                  state_next = isc_pkg::ST_PASS;
				endcase
			end
			isc_pkg::ST_PASS: begin
				cmd.pass_write = 1'b1;
				state_next     = isc_pkg::ST_FINISH;
			end
			isc_pkg::ST_LP_MUL_A: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = isc_pkg::MUL_ALPHA_MEM;
				state_next  = isc_pkg::ST_LP_MUL_B;
			end
			isc_pkg::ST_LP_MUL_B: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = isc_pkg::MUL_BETA_VALUE;
				state_next  = isc_pkg::ST_LP_SUM;
			end
			isc_pkg::ST_LP_SUM: begin
				cmd.lp_write = 1'b1;
				state_next   = isc_pkg::ST_FINISH;
			end
			isc_pkg::ST_DB_MUL_LV: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = isc_pkg::MUL_VALUE_TOP;
				state_next  = isc_pkg::ST_DB_DIV_LV;
			end
			isc_pkg::ST_DB_DIV_LV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = isc_pkg::DIV_BY_FULL_SCALE;
				state_next    = isc_pkg::ST_DB_WAIT_LV;
			end
			isc_pkg::ST_DB_WAIT_LV: begin
				if (!status.div_busy) begin
					state_next = isc_pkg::ST_DB_UPDATE;
				end
			end
			isc_pkg::ST_DB_UPDATE: begin
				cmd.db_update = 1'b1;
				state_next    = isc_pkg::ST_DB_MUL_OUT;
			end
			isc_pkg::ST_DB_MUL_OUT: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = isc_pkg::MUL_CUR_FS;
				state_next  = isc_pkg::ST_DB_DIV_OUT;
			end
			isc_pkg::ST_DB_DIV_OUT: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = isc_pkg::DIV_BY_TOP;
				state_next    = isc_pkg::ST_DB_WAIT_OUT;
			end
			isc_pkg::ST_DB_WAIT_OUT: begin
				if (!status.div_busy) begin
					state_next = isc_pkg::ST_DB_RESULT;
				end
			end
			isc_pkg::ST_DB_RESULT: begin
				cmd.db_result = 1'b1;
				state_next    = isc_pkg::ST_FINISH;
			end
			isc_pkg::ST_FINISH: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_next   = isc_pkg::ST_IDLE;
				end
			end
			default: state_next = isc_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/input_sample_conditioner.sv @@
// channel   dir  fields                                           request when
// samples   in   sample[15:0], now_ms[31:0]                       valid && ready
// results   out  conditioned_value, accepted_level, changed,      valid && ready
//                rose, fell
// cfg       in   index[2:0], data[15:0] (always ready)            valid && ready
//
// Pass, low-pass and debounce requests each step through their own states to
// the output register; the next request is taken only after that load.
// Debounce makes two runs of the shared divider (level, then remap).
// Reset is asynchronous and clears configuration and filter state; no clearing pass.
// A finished result waits in the output register while the next request is
// taken; that item completes only once the register is free.
module input_sample_conditioner #(
	parameter int ALPHA_FRACTION_BITS  = isc_pkg::ALPHA_FRACTION_BITS_DEF,
	parameter int MEMORY_FRACTION_BITS = isc_pkg::MEMORY_FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	isc_sample_if.sink          samples,
	isc_result_if.source        results,
	isc_cfg_if.sink             cfg
);

	isc_pkg::cmd_t    cmd;
	isc_pkg::status_t status;

	assign cfg.ready = 1'b1;

	isc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	isc_datapath #(
		.ALPHA_FRACTION_BITS  (ALPHA_FRACTION_BITS),
		.MEMORY_FRACTION_BITS (MEMORY_FRACTION_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_write         (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.sample            (samples.sample),
		.now_ms            (samples.now_ms),
		.conditioned_value (results.conditioned_value),
		.accepted_level    (results.accepted_level),
		.changed           (results.changed),
		.rose              (results.rose),
		.fell              (results.fell)
	);

endmodule

@@ tb/tb_input_sample_conditioner.sv @@
`timescale 1ns / 1ps

module tb_input_sample_conditioner;
	import isc_pkg::*;

	localparam int A_BITS = ALPHA_FRACTION_BITS_DEF;
	localparam int M_BITS = MEMORY_FRACTION_BITS_DEF;
	localparam longint unsigned UNITY = 64'd1 << A_BITS;
	localparam int RANDOM_PHASES = 19;
	localparam int PHASE_ITEMS = 50;
	localparam int SETTLE_CYCLES = 50;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [VALUE_W-1:0] level;
		logic               changed;
		logic               rose;
		logic               fell;
	} cond_result_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_BURST
	} stall_kind_t;

	logic clk = 1'b0;
	logic arst_n;

	isc_sample_if smp_if ();
	isc_result_if res_if ();
	isc_cfg_if    cfg_if ();

	input_sample_conditioner i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp_if),
		.results (res_if),
		.cfg     (cfg_if)
	);

	// predictor copy of the registers and the filter state
	logic [1:0]  dig_mode;
	logic [1:0]  smooth_mode;
	logic [15:0] thr_high;
	logic [15:0] thr_low;
	logic [15:0] alpha;
	logic [15:0] stable_ms;
	logic [15:0] db_levels;
	logic [15:0] fs_code;
	logic [23:0] mem_q;
	logic [15:0] prev_level;
	logic [31:0] change_stamp;

	cond_result_t pending[$];
	cond_result_t seen;
	cond_result_t want;
	int unsigned  fault_count = 0;
	int unsigned  result_no = 0;
	int unsigned  burst_left = 0;
	int unsigned  stall_left = 0;
	stall_kind_t  stall_kind = STALL_NONE;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic cond_result_t condition_sample(input logic [15:0] raw,
		input logic [31:0] now);
		cond_result_t r;
		longint unsigned v, fs, top, wt, acc, lv, cur;
		logic [31:0] elapsed;
		logic hit;
		r = '0;
		v = raw;
		fs = (fs_code == 16'd0) ? 64'd1 : fs_code;
		top = ((db_levels < 16'd2) ? 64'd2 : db_levels) - 64'd1;
		if (dig_mode == DIG_COMPARE) begin
			v = (v > thr_high) ? fs : 64'd0;
		end else if (dig_mode == DIG_SCHMITT) begin
			hit = (mem_q != 24'd0) ? (v >= thr_low) : (v > thr_high);
			v = hit ? fs : 64'd0;
		end
		case (smooth_mode)
			SMOOTH_LOWPASS: begin
				wt = (alpha > UNITY) ? UNITY : alpha;
				acc = wt * mem_q + (UNITY - wt) * (v << M_BITS);
				mem_q = 24'(acc >> A_BITS);
				r.value = 16'(mem_q >> M_BITS);
			end
			SMOOTH_DEBOUNCE: begin
				lv = (v * top) / fs;
				cur = mem_q >> M_BITS;
				if (lv > top)
					lv = top;
				elapsed = now - change_stamp;
				if (lv != prev_level) begin
					change_stamp = now;
				end else if (elapsed > stable_ms && lv != cur) begin
					r.fell = lv < cur;
					r.rose = lv > cur;
					r.changed = 1'b1;
					cur = lv;
					mem_q = 24'(lv << M_BITS);
				end
				prev_level = 16'(lv);
				r.level = 16'(cur);
				r.value = 16'((cur * fs) / top);
			end
			default: begin
				mem_q = 24'(v << M_BITS);
				r.value = 16'(v);
			end
		endcase
		return r;
	endfunction

	task automatic log_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic write_setting(input cfg_reg_t idx, input logic [15:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_DIGITAL_MODE: begin
				dig_mode = data[1:0];
				mem_q = '0;
			end
			REG_SMOOTHING_MODE: begin
				smooth_mode = data[1:0];
				mem_q = '0;
			end
			REG_THRESHOLD_HIGH:    thr_high = data;
			REG_THRESHOLD_LOW:     thr_low = data;
			REG_SMOOTHING_ALPHA:   alpha = data;
			REG_DEBOUNCE_DELAY_MS: stable_ms = data;
			REG_DEBOUNCE_LEVELS:   db_levels = data;
			default:               fs_code = data;
		endcase
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [15:0] raw, input logic [31:0] now);
		smp_if.valid  <= 1'b1;
		smp_if.sample <= raw;
		smp_if.now_ms <= now;
		do @(posedge clk); while (!smp_if.ready);
		pending.push_back(condition_sample(raw, now));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			smp_if.valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end
	endtask

	// hold off until every request has its result and the block has gone quiet
	task automatic drain();
		smp_if.valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_code();
		case ($urandom_range(0, 3))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0:       return thr_high + 16'($urandom_range(0, 4)) - 16'd2;
			1:       return thr_low + 16'($urandom_range(0, 4)) - 16'd2;
			2:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
			3:       return 16'($urandom_range(0, fs_code));
			default: return 16'($urandom);
		endcase
	endfunction

	// receiver: stretches of always-ready, random stalls and long stall runs
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_kind <= stall_kind_t'($urandom_range(0, 2));
			stall_left <= $urandom_range(40, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_kind)
			STALL_NONE:   res_if.ready <= 1'b1;
			STALL_RANDOM: res_if.ready <= ($urandom_range(0, 2) != 0);
			default:      res_if.ready <= (stall_left[3:0] > 4'd9);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			result_no++;
			seen = {res_if.conditioned_value, res_if.accepted_level,
				res_if.changed, res_if.rose, res_if.fell};
			if (pending.size() == 0) begin
				log_fault($sformatf("result %0d arrived with nothing outstanding",
					result_no));
			end else begin
				want = pending.pop_front();
				if (seen !== want)
					log_fault($sformatf({"result %0d: want value %0d level %0d ",
						"chg/rose/fell %b%b%b, got value %0d level %0d ",
						"chg/rose/fell %b%b%b"}, result_no,
						want.value, want.level, want.changed, want.rose, want.fell,
						seen.value, seen.level, seen.changed, seen.rose, seen.fell));
			end
		end
	end

	task automatic test_pass_modes();
		drain();
		send_sample(16'd0, 32'd0);
		send_sample(16'hFFFF, 32'hFFFF_FFFF);
		send_sample(16'hAAAA, 32'hAAAA_AAAA);
		send_sample(16'h5555, 32'h5555_5555);
		drain();
		// unused mode codes, with the upper data bits set
		write_setting(REG_DIGITAL_MODE, 16'hFFFF);
		write_setting(REG_SMOOTHING_MODE, 16'hFFFF);
		send_sample(16'h1234, 32'd7);
		send_sample(16'hFEDC, 32'd8);
	endtask

	task automatic test_compare();
		drain();
		write_setting(REG_DIGITAL_MODE, 16'(DIG_COMPARE));
		write_setting(REG_SMOOTHING_MODE, 16'(SMOOTH_NONE));
		write_setting(REG_THRESHOLD_HIGH, 16'h8000);
		write_setting(REG_FULL_SCALE, 16'd0);
		send_sample(16'h8000, 32'd1);
		send_sample(16'h8001, 32'd2);
		drain();
		write_setting(REG_FULL_SCALE, 16'hFFFF);
		send_sample(16'hFFFF, 32'd3);
	endtask

	task automatic test_schmitt();
		drain();
		write_setting(REG_DIGITAL_MODE, 16'(DIG_SCHMITT));
		write_setting(REG_THRESHOLD_HIGH, 16'd40000);
		write_setting(REG_THRESHOLD_LOW, 16'd20000);
		write_setting(REG_FULL_SCALE, 16'd1000);
		send_sample(16'd30000, 32'd10);
		send_sample(16'd40001, 32'd11);
		send_sample(16'd30000, 32'd12);
		send_sample(16'd19999, 32'd13);
	endtask

	task automatic test_lowpass();
		drain();
		write_setting(REG_DIGITAL_MODE, 16'(DIG_PASS));
		write_setting(REG_SMOOTHING_MODE, 16'(SMOOTH_LOWPASS));
		write_setting(REG_SMOOTHING_ALPHA, 16'd0);
		send_sample(16'hFFFF, 32'd20);
		drain();
		write_setting(REG_SMOOTHING_ALPHA, 16'hFFFF);
		send_sample(16'd0, 32'd21);
		send_sample(16'd0, 32'd22);
		drain();
		write_setting(REG_SMOOTHING_ALPHA, 16'h8000);
		send_sample(16'd1000, 32'd23);
	endtask

	task automatic test_debounce();
		drain();
		write_setting(REG_SMOOTHING_MODE, 16'(SMOOTH_DEBOUNCE));
		write_setting(REG_DEBOUNCE_LEVELS, 16'd0);
		write_setting(REG_FULL_SCALE, 16'd100);
		write_setting(REG_DEBOUNCE_DELAY_MS, 16'd5);
		// well above full scale so the level saturates
		send_sample(16'd250, 32'd10);
		send_sample(16'd250, 32'd15);
		send_sample(16'd250, 32'd16);
		send_sample(16'd0, 32'd17);
		send_sample(16'd0, 32'hFFFF_FFF0);
		// stable time measured across the counter wrap
		send_sample(16'd250, 32'hFFFF_FFFE);
		send_sample(16'd250, 32'd4);
	endtask

	task automatic configure_phase(input int ph);
		logic [15:0] vals [8];
		if (ph == 0) begin
			vals = '{16'(DIG_SCHMITT), 16'(SMOOTH_DEBOUNCE), 16'hFFFF, 16'hFFFF,
				16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		end else if (ph == 1) begin
			vals = '{16'(DIG_PASS), 16'(SMOOTH_NONE), 16'd0, 16'd0, 16'd0, 16'd0,
				16'd0, 16'd0};
		end else begin
			vals[REG_DIGITAL_MODE] = 16'($urandom_range(0, 3));
			case ($urandom_range(0, 5))
				0:       vals[REG_SMOOTHING_MODE] = 16'(SMOOTH_NONE);
				1, 2:    vals[REG_SMOOTHING_MODE] = 16'(SMOOTH_LOWPASS);
				5:       vals[REG_SMOOTHING_MODE] = 16'd3;
				default: vals[REG_SMOOTHING_MODE] = 16'(SMOOTH_DEBOUNCE);
			endcase
			vals[REG_THRESHOLD_HIGH] = pick_code();
			vals[REG_THRESHOLD_LOW] = pick_code();
			vals[REG_SMOOTHING_ALPHA] = ($urandom_range(0, 4) == 0) ? 16'd1 : pick_code();
			vals[REG_DEBOUNCE_DELAY_MS] = ($urandom_range(0, 5) == 0) ? pick_code()
				: 16'($urandom_range(0, 30));
			case ($urandom_range(0, 5))
				0:       vals[REG_DEBOUNCE_LEVELS] = 16'($urandom_range(0, 2));
				1:       vals[REG_DEBOUNCE_LEVELS] = pick_code();
				default: vals[REG_DEBOUNCE_LEVELS] = 16'($urandom_range(3, 16));
			endcase
			vals[REG_FULL_SCALE] = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 300))
				: pick_code();
		end
		for (int i = 0; i < 8; i++)
			write_setting(cfg_reg_t'(i), vals[i]);
	endtask

	// held levels with random content and the odd stray sample, time mostly creeping
	task automatic test_random();
		logic [31:0] now;
		logic [15:0] target, raw;
		int unsigned hold;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			configure_phase(ph);
			now = (ph % 3 == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 200) : $urandom;
			hold = 0;
			repeat (PHASE_ITEMS) begin
				if (hold == 0) begin
					target = pick_sample();
					hold = $urandom_range(1, 12);
				end
				hold--;
				raw = ($urandom_range(0, 9) == 0) ? 16'($urandom) : target;
				now += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 8);
				send_sample(raw, now);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		smp_if.valid = 1'b0;
		smp_if.sample = '0;
		smp_if.now_ms = '0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_DIGITAL_MODE;
		cfg_if.data = '0;
		dig_mode = DIG_PASS;
		smooth_mode = SMOOTH_NONE;
		thr_high = '0;
		thr_low = '0;
		alpha = '0;
		stable_ms = '0;
		db_levels = 16'd2;
		fs_code = 16'd1;
		mem_q = '0;
		prev_level = '0;
		change_stamp = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pass_modes();
		test_compare();
		test_schmitt();
		test_lowpass();
		test_debounce();
		test_random();
		drain();
		if (fault_count == 0 && pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
